// ===== hdl/rhzt_pkg.sv =====
// shared types and constants for the rectangle hit zone table
package rhzt_pkg;

   // table geometry
   localparam int NUM_ZONES = 16;
   localparam int SLOT_W    = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
   localparam int CNT_W     = $clog2(NUM_ZONES + 1);
   localparam int ZONES_W   = 5;
   localparam int ZONES_RESET = 16;

   // register map
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;
   localparam logic REG_ZONES_IN_USE = 1'b0;

   // operation codes
   typedef enum logic [2:0] {
      OP_ADD        = 3'd0,
      OP_DELETE     = 3'd1,
      OP_UPDATE     = 3'd2,
      OP_SET_ACTIVE = 3'd3,
      OP_CHECK      = 3'd4
   } op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   // request word
   typedef struct packed {
      logic [2:0]         operation;
      logic [15:0]        zone_id;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [14:0]        rect_width;
      logic [14:0]        rect_height;
      logic [1:0]         button_mask;
      logic               enable_value;
      logic [15:0]        filter_first;
      logic [15:0]        filter_second;
   } req_type;

   // response word
   typedef struct packed {
      logic        found;
      logic [3:0]  slot_index;
      logic [15:0] hit_zone;
   } rsp_type;

endpackage

// ===== hdl/rectangle_hit_zone_table.sv =====
// rectangle hit zone table: slot scanner with one compare unit and apb register port
//
//   channel  | direction | handshake             | word
//   ---------+-----------+-----------------------+-----------------------
//   req      | in        | req_valid / req_ready | rhzt_pkg::req_type
//   rsp      | out       | rsp_valid / rsp_ready | rhzt_pkg::rsp_type
//   csr      | in/out    | psel/penable/pready   | zones_in_use at 0x0
//
// a word visits one slot at a time in the single slot compare unit and stops at the first hit;
// a miss visits every slot up to the slot count (zones_in_use, capped at 16).
// add/delete/update/set_active scan upward from slot 0, check scans downward.
// reset clears the active marks and ids; writing zones_in_use does the same.
// a new word is taken while the previous response still waits on rsp_ready;
// the block holds its result in place until the response register frees up.
module rectangle_hit_zone_table (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rhzt_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rhzt_pkg::rsp_type              rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [rhzt_pkg::PADDR_W-1:0]   paddr,
   input  logic [rhzt_pkg::PDATA_W-1:0]   pwdata,
   output logic [rhzt_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);

   // control state
   rhzt_pkg::state_type state_ff, state_in;
   logic [rhzt_pkg::ZONES_W-1:0] zones_ff, zones_in;
   logic [rhzt_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [rhzt_pkg::SLOT_W-1:0]  idx_ff, idx_in;
   logic [rhzt_pkg::SLOT_W-1:0]  free_ff, free_in;
   logic                         free_vld_ff, free_vld_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // table
   logic        active_ff  [rhzt_pkg::NUM_ZONES];
   logic        active_in  [rhzt_pkg::NUM_ZONES];
   logic [15:0] zone_ff    [rhzt_pkg::NUM_ZONES];
   logic [15:0] zone_in    [rhzt_pkg::NUM_ZONES];
   logic [1:0]  buttons_ff [rhzt_pkg::NUM_ZONES];
   logic signed [15:0] left_ff [rhzt_pkg::NUM_ZONES];
   logic signed [15:0] top_ff  [rhzt_pkg::NUM_ZONES];
   logic [14:0] wide_ff    [rhzt_pkg::NUM_ZONES];
   logic [14:0] tall_ff    [rhzt_pkg::NUM_ZONES];

   // payload
   rhzt_pkg::req_type item_ff, item_in;
   rhzt_pkg::rsp_type res_ff, res_in;
   rhzt_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // field write request
   logic                        wr_en;
   logic [rhzt_pkg::SLOT_W-1:0] wr_slot;

   // compare unit signals
   logic [rhzt_pkg::CNT_W-1:0]  slots_n;
   logic [rhzt_pkg::SLOT_W-1:0] slot;
   logic                        live;
   logic                        cur_active;
   logic [15:0]                 cur_zone;
   logic                        id_match;
   logic                        filt_match;
   logic signed [16:0]          right_edge;
   logic signed [16:0]          bottom_edge;
   logic signed [16:0]          probe_x;
   logic signed [16:0]          probe_y;
   logic                        inside_rect;
   logic                        slot_hit;
   logic                        cfg_write;

   // slots searched, capped at table size
   assign slots_n = (int'(zones_ff) > rhzt_pkg::NUM_ZONES) ?
                    rhzt_pkg::CNT_W'(rhzt_pkg::NUM_ZONES) : rhzt_pkg::CNT_W'(zones_ff);

   // the shared slot compare unit
   assign slot        = idx_ff;
   assign live        = (cnt_ff != '0);
   assign cur_active  = active_ff[slot];
   assign cur_zone    = zone_ff[slot];
   assign id_match    = (cur_zone == item_ff.zone_id);
   assign filt_match  = (cur_zone == item_ff.filter_first) ||
                        (cur_zone == item_ff.filter_second);
   assign right_edge  = 17'(left_ff[slot]) + $signed({2'b00, wide_ff[slot]});
   assign bottom_edge = 17'(top_ff[slot]) + $signed({2'b00, tall_ff[slot]});
   assign probe_x     = 17'(item_ff.pos_x);
   assign probe_y     = 17'(item_ff.pos_y);
   assign inside_rect = (17'(left_ff[slot]) <= probe_x) && (17'(top_ff[slot]) <= probe_y) &&
                        (right_edge >= probe_x) && (bottom_edge >= probe_y);

   // per-operation hit test for the current slot
   always_comb begin
      case (item_ff.operation)
         rhzt_pkg::OP_ADD:        slot_hit = !cur_active;
         rhzt_pkg::OP_DELETE:     slot_hit = cur_active && id_match;
         rhzt_pkg::OP_UPDATE:     slot_hit = cur_active && id_match;
         rhzt_pkg::OP_SET_ACTIVE: slot_hit = id_match;
         rhzt_pkg::OP_CHECK:      slot_hit = cur_active && filt_match && inside_rect &&
                                             (buttons_ff[slot] == item_ff.button_mask);
         default:                 slot_hit = 1'b0;
      endcase
   end

   // register port
   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == rhzt_pkg::REG_ZONES_IN_USE) ?
                      rhzt_pkg::PDATA_W'(zones_ff) : '0;

   // handshake outputs
   assign req_ready = (state_ff == rhzt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // sequencer: next state and next values
   always_comb begin
      state_in     = state_ff;
      zones_in     = zones_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      free_in      = free_ff;
      free_vld_in  = free_vld_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      active_in    = active_ff;
      zone_in      = zone_ff;
      wr_en        = 1'b0;
      wr_slot      = slot;

      case (state_ff)
         rhzt_pkg::ST_IDLE: begin
            // take a word and set up the scan
            if (req_valid) begin
               item_in     = req_data;
               cnt_in      = slots_n;
               free_vld_in = 1'b0;
               if (req_data.operation == rhzt_pkg::OP_CHECK) begin
                  idx_in = rhzt_pkg::SLOT_W'(slots_n - rhzt_pkg::CNT_W'(1));
               end else begin
                  idx_in = '0;
               end
               state_in = rhzt_pkg::ST_SCAN;
            end
         end
         rhzt_pkg::ST_SCAN: begin
            res_in = '0;
            if (!live) begin
               // end of table: update falls back to add at the first free slot
               if ((item_ff.operation == rhzt_pkg::OP_UPDATE) && free_vld_ff) begin
                  active_in[free_ff] = 1'b1;
                  zone_in[free_ff]   = item_ff.zone_id;
                  wr_en              = 1'b1;
                  wr_slot            = free_ff;
                  res_in.found       = 1'b1;
                  res_in.slot_index  = 4'(free_ff);
               end
               state_in = rhzt_pkg::ST_DONE;
            end else if (slot_hit) begin
               // act on the matched slot
               res_in.found      = 1'b1;
               res_in.slot_index = 4'(slot);
               case (item_ff.operation)
                  rhzt_pkg::OP_ADD: begin
                     active_in[slot] = 1'b1;
                     zone_in[slot]   = item_ff.zone_id;
                     wr_en           = 1'b1;
                  end
                  rhzt_pkg::OP_DELETE:     active_in[slot] = 1'b0;
                  rhzt_pkg::OP_UPDATE:     wr_en = 1'b1;
                  rhzt_pkg::OP_SET_ACTIVE: active_in[slot] = item_ff.enable_value;
                  rhzt_pkg::OP_CHECK:      res_in.hit_zone = cur_zone;
                  default:                 res_in = '0;
               endcase
               state_in = rhzt_pkg::ST_DONE;
            end else begin
               // step to the next slot, remembering the first free one
               if (!cur_active && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_in     = slot;
               end
               cnt_in = cnt_ff - rhzt_pkg::CNT_W'(1);
               if (item_ff.operation == rhzt_pkg::OP_CHECK) begin
                  idx_in = idx_ff - rhzt_pkg::SLOT_W'(1);
               end else begin
                  idx_in = idx_ff + rhzt_pkg::SLOT_W'(1);
               end
            end
         end
         rhzt_pkg::ST_DONE: begin
            // hand the result over once the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = rhzt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rhzt_pkg::ST_IDLE;
         end
      endcase

      // register write reinitializes the table
      if (cfg_write && (paddr[2] == rhzt_pkg::REG_ZONES_IN_USE)) begin
         zones_in = pwdata[rhzt_pkg::ZONES_W-1:0];
         for (int i = 0; i < rhzt_pkg::NUM_ZONES; i++) begin
            active_in[i] = 1'b0;
            zone_in[i]   = '0;
         end
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rhzt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control registers and table marks
   always_ff @(posedge clock) begin
      if (reset) begin
         zones_ff     <= rhzt_pkg::ZONES_W'(rhzt_pkg::ZONES_RESET);
         cnt_ff       <= '0;
         idx_ff       <= '0;
         free_ff      <= '0;
         free_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rhzt_pkg::NUM_ZONES; i++) begin
            active_ff[i] <= 1'b0;
            zone_ff[i]   <= '0;
         end
      end else begin
         zones_ff     <= zones_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         free_ff      <= free_in;
         free_vld_ff  <= free_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         zone_ff      <= zone_in;
      end
   end

   // payload registers and rectangle fields
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      if (wr_en) begin
         buttons_ff[wr_slot] <= item_ff.button_mask;
         left_ff[wr_slot]    <= item_ff.pos_x;
         top_ff[wr_slot]     <= item_ff.pos_y;
         wide_ff[wr_slot]    <= item_ff.rect_width;
         tall_ff[wr_slot]    <= item_ff.rect_height;
      end
   end

endmodule

// ===== sim/tb_rectangle_hit_zone_table.sv =====
// testbench for the rectangle hit zone table: directed table, then random words per slot count
`timescale 1ns / 100ps

module tb_rectangle_hit_zone_table;

   localparam int WORD_W       = $bits(rhzt_pkg::req_type);
   localparam int LIMIT_CYCLES = 400000;
   localparam int TAIL_CYCLES  = 24;
   localparam int LONG_HOLD    = 300;
   localparam int POOL_SIZE    = 6;
   localparam int NUM_PHASES   = 8;
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
   localparam logic [rhzt_pkg::PADDR_W-1:0] ZONES_ADDR =
      rhzt_pkg::PADDR_W'(4 * int'(rhzt_pkg::REG_ZONES_IN_USE));

   typedef struct packed {
      rhzt_pkg::req_type word;
      bit                typed;
      rhzt_pkg::rsp_type want;
   } plan_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rhzt_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rhzt_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [rhzt_pkg::PADDR_W-1:0] paddr = '0;
   logic [rhzt_pkg::PDATA_W-1:0] pwdata = '0;
   logic [rhzt_pkg::PDATA_W-1:0] prdata;
   logic pready;

   // shadow copy of the zone table
   bit              slot_on      [rhzt_pkg::NUM_ZONES];
   bit [15:0]       slot_id      [rhzt_pkg::NUM_ZONES];
   bit [1:0]        slot_btn     [rhzt_pkg::NUM_ZONES];
   bit signed [15:0] slot_left   [rhzt_pkg::NUM_ZONES];
   bit signed [15:0] slot_top    [rhzt_pkg::NUM_ZONES];
   bit [14:0]       slot_wide    [rhzt_pkg::NUM_ZONES];
   bit [14:0]       slot_tall    [rhzt_pkg::NUM_ZONES];
   bit              slot_written [rhzt_pkg::NUM_ZONES];
   int unsigned     zones_cfg = rhzt_pkg::ZONES_RESET;

   rhzt_pkg::rsp_type due_rsp [$];
   plan_row_type plan [$];
   int  mismatches = 0;
   int  cycle_count = 0;
   int  idle_pct = 20;
   bit  calm = 1'b0;
   bit  hold_rsp = 1'b0;

   rectangle_hit_zone_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // slot count actually searched, capped at the table size
   function automatic int scan_limit();
      return (zones_cfg > rhzt_pkg::NUM_ZONES) ? rhzt_pkg::NUM_ZONES : int'(zones_cfg);
   endfunction

   function automatic void store_rect(int i, rhzt_pkg::req_type w);
      slot_btn[i]     = w.button_mask;
      slot_left[i]    = w.pos_x;
      slot_top[i]     = w.pos_y;
      slot_wide[i]    = w.rect_width;
      slot_tall[i]    = w.rect_height;
      slot_written[i] = 1'b1;
   endfunction

   // first inactive slot takes the new zone
   function automatic int claim_free(rhzt_pkg::req_type w);
      for (int i = 0; i < scan_limit(); i++) begin
         if (!slot_on[i]) begin
            slot_on[i] = 1'b1;
            slot_id[i] = w.zone_id;
            store_rect(i, w);
            return i;
         end
      end
      return -1;
   endfunction

   function automatic int find_live(logic [15:0] id);
      for (int i = 0; i < scan_limit(); i++)
         if (slot_on[i] && slot_id[i] == id) return i;
      return -1;
   endfunction

   // id match regardless of the active mark
   function automatic int first_with_id(logic [15:0] id);
      for (int i = 0; i < scan_limit(); i++)
         if (slot_id[i] == id) return i;
      return -1;
   endfunction

   // apply one word to the shadow table and return its response
   function automatic rhzt_pkg::rsp_type predict_zone_op(rhzt_pkg::req_type w);
      rhzt_pkg::rsp_type r;
      int slot;
      int px;
      int py;
      r = '0;
      slot = -1;
      px = int'(w.pos_x);
      py = int'(w.pos_y);
      case (w.operation)
         rhzt_pkg::OP_ADD: slot = claim_free(w);
         rhzt_pkg::OP_DELETE: begin
            slot = find_live(w.zone_id);
            if (slot >= 0) slot_on[slot] = 1'b0;
         end
         rhzt_pkg::OP_UPDATE: begin
            slot = find_live(w.zone_id);
            if (slot >= 0) store_rect(slot, w);
            else slot = claim_free(w);
         end
         rhzt_pkg::OP_SET_ACTIVE: begin
            slot = first_with_id(w.zone_id);
            if (slot >= 0) slot_on[slot] = w.enable_value;
         end
         rhzt_pkg::OP_CHECK: begin
            // top slot down, edges count as inside
            for (int i = scan_limit() - 1; i >= 0; i--) begin
               if (slot < 0 && slot_on[i] &&
                   (slot_id[i] == w.filter_first || slot_id[i] == w.filter_second) &&
                   slot_btn[i] == w.button_mask &&
                   slot_left[i] <= px && slot_top[i] <= py &&
                   int'(slot_left[i]) + int'(slot_wide[i]) >= px &&
                   int'(slot_top[i]) + int'(slot_tall[i]) >= py) begin
                  slot = i;
                  r.hit_zone = slot_id[i];
               end
            end
         end
         default: ;
      endcase
      if (slot >= 0) begin
         r.found = 1'b1;
         r.slot_index = 4'(slot);
      end
      return r;
   endfunction

   function automatic rhzt_pkg::req_type mk_word(logic [2:0] op, logic [15:0] id,
                                                 int x, int y, int wd, int ht,
                                                 int btn, int en,
                                                 logic [15:0] f1, logic [15:0] f2);
      rhzt_pkg::req_type w;
      w.operation     = op;
      w.zone_id       = id;
      w.pos_x         = 16'(x);
      w.pos_y         = 16'(y);
      w.rect_width    = 15'(wd);
      w.rect_height   = 15'(ht);
      w.button_mask   = 2'(btn);
      w.enable_value  = 1'(en);
      w.filter_first  = f1;
      w.filter_second = f2;
      return w;
   endfunction

   task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
   endtask

   // offer one word, predict it once the block takes it
   task automatic offer_word(rhzt_pkg::req_type w, bit typed, rhzt_pkg::rsp_type want);
      rhzt_pkg::rsp_type r;
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_data  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      r = predict_zone_op(w);
      due_rsp.push_back(typed ? want : r);
   endtask

   // stop offering and wait for every response
   task automatic settle(bit with_tail);
      req_valid <= 1'b0;
      do @(posedge clock); while (due_rsp.size() != 0);
      if (with_tail) repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // write zones_in_use, read it back, and clear the shadow table
   task automatic csr_set(logic [4:0] zones);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ZONES_ADDR;
      pwdata  <= {27'($urandom), zones};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(zones)) note_mismatch("zones_in_use readback", 32'(zones), prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      zones_cfg = 32'(zones);
      for (int i = 0; i < rhzt_pkg::NUM_ZONES; i++) begin
         slot_on[i] = 1'b0;
         slot_id[i] = '0;
      end
   endtask

   // response side ready, with random stalls and one long hold-off
   initial begin : rsp_side
      int stall;
      stall = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
            rsp_ready <= 1'b0;
            stall = $urandom_range(0, 13);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each response word with the oldest expectation
   always @(posedge clock) begin : rsp_check
      rhzt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp.size() == 0) begin
            note_mismatch("unexpected response word", '0, 32'(rsp_data));
         end else begin
            want = due_rsp.pop_front();
            if (rsp_data.found !== want.found)
               note_mismatch("found", 32'(want.found), 32'(rsp_data.found));
            if (rsp_data.slot_index !== want.slot_index)
               note_mismatch("slot_index", 32'(want.slot_index), 32'(rsp_data.slot_index));
            if (rsp_data.hit_zone !== want.hit_zone)
               note_mismatch("hit_zone", 32'(want.hit_zone), 32'(rsp_data.hit_zone));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      rhzt_pkg::req_type w;
      int pick;
      int s;
      int off_x;
      int off_y;
      int px;
      int py;
      int live [$];
      logic [15:0] id_pool [POOL_SIZE];
      logic [4:0] phase_zones [NUM_PHASES];
      int phase_len [NUM_PHASES];
      int phase_idle [NUM_PHASES];

      phase_zones = '{5'd0, 5'd31, 5'd1, 5'd3, 5'd16, 5'd17, 5'd9, 5'd16};
      phase_len   = '{30, 130, 50, 90, 150, 100, 130, 120};
      phase_idle  = '{15, 25, 0, 30, 10, 20, 35, 0};
      phase_zones[6] = 5'($urandom_range(2, 15));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words: reset state, extremes, misses, priority of the top slot
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0000, 0, 0, 0, 0, 0, 0,
                               16'h0000, 16'h0000), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_SET_ACTIVE, 16'h0000, 0, 0, 0, 0, 0, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_DELETE, 16'h1234, 0, 0, 0, 0, 0, 0,
                               16'h0, 16'h0), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_ADD, 16'hFFFF, -32768, -32768, 32767, 32767,
                               3, 1, 16'h0, 16'h0), 1'b1, {1'b1, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_ADD, 16'h0001, 32767, 32767, 32767, 32767,
                               0, 0, 16'h0, 16'h0), 1'b1, {1'b1, 4'd1, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, -1, -1, 0, 0, 3, 0,
                               16'hFFFF, 16'h0000), 1'b1, {1'b1, 4'd0, 16'hFFFF}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, 0, -1, 0, 0, 3, 0,
                               16'hFFFF, 16'h0000), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, 32767, 32767, 0, 0, 0, 0,
                               16'h0000, 16'h0001), 1'b1, {1'b1, 4'd1, 16'h0001}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, -32768, -32768, 0, 0, 3, 0,
                               16'hFFFF, 16'h0000), 1'b1, {1'b1, 4'd0, 16'hFFFF}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, -100, -100, 0, 0, 2, 0,
                               16'hFFFF, 16'h0000), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_UPDATE, 16'h0001, -10, -10, 0, 0, 1, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd1, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, -10, -10, 0, 0, 1, 0,
                               16'h0001, 16'h0001), 1'b1, {1'b1, 4'd1, 16'h0001}});
      plan.push_back('{mk_word(rhzt_pkg::OP_UPDATE, 16'h0202, 5, 5, 10, 10, 2, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd2, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_SET_ACTIVE, 16'hFFFF, 0, 0, 0, 0, 0, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, -1, -1, 0, 0, 3, 0,
                               16'hFFFF, 16'h0000), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_SET_ACTIVE, 16'hFFFF, 0, 0, 0, 0, 0, 1,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_DELETE, 16'h0001, 0, 0, 0, 0, 0, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd1, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_ADD, 16'h0303, 0, 0, 1, 1, 1, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd1, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_SET_ACTIVE, 16'h5555, 0, 0, 0, 0, 0, 1,
                               16'h0, 16'h0), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(OP_UNUSED_FIRST, 16'hFFFF, -1, -1, 32767, 32767, 3, 1,
                               16'hFFFF, 16'hFFFF), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(OP_UNUSED_LAST, 16'h0303, 0, 0, 0, 0, 1, 1,
                               16'h0303, 16'h0303), 1'b1, {1'b0, 4'd0, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_ADD, 16'h0404, -5, -5, 100, 100, 2, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd3, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_UPDATE, 16'h0202, -5, -5, 100, 100, 2, 0,
                               16'h0, 16'h0), 1'b1, {1'b1, 4'd2, 16'h0000}});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, 0, 0, 0, 0, 2, 0,
                               16'h0202, 16'h0404), 1'b0, '0});
      plan.push_back('{mk_word(rhzt_pkg::OP_CHECK, 16'h0, 0, 0, 0, 0, 2, 0,
                               16'h0202, 16'h7777), 1'b0, '0});

      foreach (plan[i]) offer_word(plan[i].word, plan[i].typed, plan[i].want);
      settle(1'b1);

      // random words, one block per slot count
      for (int p = 0; p < NUM_PHASES; p++) begin
         csr_set(phase_zones[p]);
         idle_pct = phase_idle[p];
         calm = (p == NUM_PHASES - 1);
         for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);
         id_pool[0] = p[0] ? 16'h0000 : 16'hFFFF;

         for (int k = 0; k < phase_len[p]; k++) begin
            // long response hold-off while words keep coming
            if (p == 1 && k == 40) hold_rsp = 1'b1;
            // sender waits for every response mid-stream
            if (p == 4 && k == 75) settle(1'b0);

            w = WORD_W'({$urandom, $urandom, $urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 20) w.operation = rhzt_pkg::OP_ADD;
            else if (pick < 32) w.operation = rhzt_pkg::OP_DELETE;
            else if (pick < 47) w.operation = rhzt_pkg::OP_UPDATE;
            else if (pick < 57) w.operation = rhzt_pkg::OP_SET_ACTIVE;
            else if (pick < 95) w.operation = rhzt_pkg::OP_CHECK;
            else w.operation = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));

            if ($urandom_range(0, 9) != 0) w.zone_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];

            case (w.operation)
               rhzt_pkg::OP_ADD, rhzt_pkg::OP_UPDATE: begin
                  // mostly small rectangles clustered near the origin so they overlap
                  if ($urandom_range(0, 4) != 0) begin
                     w.pos_x       = 16'(int'($urandom_range(0, 400)) - 200);
                     w.pos_y       = 16'(int'($urandom_range(0, 400)) - 200);
                     w.rect_width  = 15'($urandom_range(0, 80));
                     w.rect_height = 15'($urandom_range(0, 80));
                  end
               end
               rhzt_pkg::OP_SET_ACTIVE: begin
                  // never activate a slot whose rectangle was never written
                  s = first_with_id(w.zone_id);
                  if (s >= 0 && w.enable_value && !slot_written[s]) w.enable_value = 1'b0;
               end
               rhzt_pkg::OP_CHECK: begin
                  live.delete();
                  for (int i = 0; i < scan_limit(); i++)
                     if (slot_on[i]) live.push_back(i);
                  w.filter_first  = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                  w.filter_second = id_pool[$urandom_range(0, POOL_SIZE - 1)];
                  if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
                     // aim at a live zone, on its edges, inside or one step outside
                     s = live[$urandom_range(0, live.size() - 1)];
                     case ($urandom_range(0, 4))
                        0: off_x = 0;
                        1: off_x = int'(slot_wide[s]);
                        2: off_x = int'(slot_wide[s]) + 1;
                        default: off_x = $urandom_range(0, slot_wide[s]);
                     endcase
                     case ($urandom_range(0, 4))
                        0: off_y = 0;
                        1: off_y = int'(slot_tall[s]);
                        2: off_y = int'(slot_tall[s]) + 1;
                        default: off_y = $urandom_range(0, slot_tall[s]);
                     endcase
                     px = int'(slot_left[s]) + off_x;
                     py = int'(slot_top[s]) + off_y;
                     if (px > 32767) px = 32767;
                     if (py > 32767) py = 32767;
                     w.pos_x = 16'(px);
                     w.pos_y = 16'(py);
                     if ($urandom_range(0, 9) != 0) w.button_mask = slot_btn[s];
                     if ($urandom_range(0, 1)) w.filter_first = slot_id[s];
                     else w.filter_second = slot_id[s];
                  end
               end
               default: ;
            endcase

            offer_word(w, 1'b0, '0);
         end
         settle(1'b1);
      end

      if (mismatches == 0 && due_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
